@@ sv/vag_pkg.sv @@
// Shared types, constants and coefficient tables for the VAG ADPCM block decoder.
`default_nettype none

package vag_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned FILTER_W  = 3;
   localparam int unsigned SHIFT_W   = 4;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned COEF_W    = 8;
   localparam int unsigned PROD_W    = SAMPLE_W + COEF_W;
   localparam int unsigned ACC_W     = PROD_W + 2;
   localparam int unsigned PRED_W    = ACC_W - 6;
   localparam int unsigned TOTAL_W   = PRED_W + 1;

   localparam logic [3:0]  MAX_FILTER   = 4'd4;
   localparam logic [3:0]  MAX_SHIFT    = 4'd12;
   localparam logic [POS_W-1:0] POS_IDLE   = 4'd0;
   localparam logic [POS_W-1:0] POS_FLAGS  = 4'd1;
   localparam logic [POS_W-1:0] POS_LAST   = 4'd15;

   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_ERROR  = 1'b1
   } op_kind_type;

   // one classified byte handed from the front to the back
   typedef struct packed {
      op_kind_type         kind;
      logic [BYTE_W-1:0]   data;
      logic [FILTER_W-1:0] filter;
      logic [SHIFT_W-1:0]  shift;
      logic                channel;
      logic                last;
   } op_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       channel;
      logic                       last;
      logic                       bad;
   } rsp_type;

   function automatic logic signed [COEF_W-1:0] coef_a(input logic [FILTER_W-1:0] f);
      logic signed [COEF_W-1:0] c;
      unique case (f)
         3'd1:    c = 8'sd60;
         3'd2:    c = 8'sd115;
         3'd3:    c = 8'sd98;
         3'd4:    c = 8'sd122;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_b(input logic [FILTER_W-1:0] f);
      logic signed [COEF_W-1:0] c;
      unique case (f)
         3'd2:    c = -8'sd52;
         3'd3:    c = -8'sd55;
         3'd4:    c = -8'sd60;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/vag_fifo.sv @@
// Small register-based FIFO used for the op queue and the result queue.
`default_nettype none

module vag_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      // write and read together leave the count alone
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/vag_front.sv @@
// Front end: tracks block position, parses the header and queues decode/error ops.
`default_nettype none

module vag_front
   import vag_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              block_start,
   input  wire logic              channel,
   output logic                   full,
   input  wire logic              cmd_full,
   output logic                   cmd_push,
   output op_type                 cmd_op
);

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [FILTER_W-1:0] filter_ff, filter_in;
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic                chan_ff, chan_in;
   logic                dropped_ff, dropped_in;
   logic                accept;
   logic                bad_hdr;

   assign full    = cmd_full;
   assign accept  = push && !cmd_full;
   assign bad_hdr = (data_byte[7:4] > MAX_FILTER) || (data_byte[3:0] > MAX_SHIFT);

   always_comb begin
      pos_in     = pos_ff;
      filter_in  = filter_ff;
      shift_in   = shift_ff;
      chan_in    = chan_ff;
      dropped_in = dropped_ff;
      cmd_push   = 1'b0;
      cmd_op.kind    = OP_DECODE;
      cmd_op.data    = data_byte;
      cmd_op.filter  = filter_ff;
      cmd_op.shift   = shift_ff;
      cmd_op.channel = chan_ff;
      cmd_op.last    = (pos_ff == POS_LAST);
      if (accept) begin
         priority if (block_start) begin
            pos_in     = POS_FLAGS;
            filter_in  = data_byte[6:4];
            shift_in   = data_byte[3:0];
            chan_in    = channel;
            dropped_in = bad_hdr;
            cmd_push   = bad_hdr;
            cmd_op.kind    = OP_ERROR;
            cmd_op.channel = channel;
            cmd_op.last    = 1'b0;
         end else if (pos_ff != POS_IDLE) begin
            pos_in   = pos_ff + 1'b1;
            cmd_push = (pos_ff != POS_FLAGS) && !dropped_ff;
         end else begin
            // stray byte with no block open: nothing changes
            cmd_push = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_IDLE;
         filter_ff  <= '0;
         shift_ff   <= '0;
         chan_ff    <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         filter_ff  <= filter_in;
         shift_ff   <= shift_in;
         chan_ff    <= chan_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/vag_back.sv @@
// Back end: per-channel history, predictor; one sample per cycle unless stalled.
`default_nettype none

module vag_back
   import vag_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 2
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   cmd_empty,
   input  op_type      cmd_op,
   output logic        cmd_pop,
   input  wire logic   rsp_full,
   output logic        rsp_push,
   output rsp_type     rsp_item
);

   localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   logic signed [SAMPLE_W-1:0] h1_ff [NUM_CHANNELS];
   logic signed [SAMPLE_W-1:0] h2_ff [NUM_CHANNELS];
   logic                       hi_nib_ff, hi_nib_in;

   logic [CH_W-1:0]            ch_idx;
   logic                       fire;
   logic                       is_decode;
   logic signed [3:0]          nib;
   logic signed [SAMPLE_W-1:0] resid;
   logic signed [SAMPLE_W-1:0] h1, h2;
   logic signed [PROD_W-1:0]   prod_a, prod_b;
   logic signed [ACC_W-1:0]    acc;
   logic signed [PRED_W-1:0]   pred;
   logic signed [TOTAL_W-1:0]  total;
   logic signed [SAMPLE_W-1:0] sample;

   assign ch_idx    = (NUM_CHANNELS > 1) ? CH_W'(cmd_op.channel) : '0;
   assign fire      = !cmd_empty && !rsp_full;
   assign is_decode = (cmd_op.kind == OP_DECODE);

   // low nibble first, then high nibble of the same byte
   assign nib    = hi_nib_ff ? $signed(cmd_op.data[7:4]) : $signed(cmd_op.data[3:0]);
   assign resid  = $signed({nib, 12'b0}) >>> cmd_op.shift;
   assign h1     = h1_ff[ch_idx];
   assign h2     = h2_ff[ch_idx];
   assign prod_a = h1 * coef_a(cmd_op.filter);
   assign prod_b = h2 * coef_b(cmd_op.filter);
   assign acc    = ACC_W'(prod_a) + ACC_W'(prod_b) + ACC_W'(32);
   assign pred   = PRED_W'(acc >>> 6);
   assign total  = TOTAL_W'(resid) + TOTAL_W'(pred);

   always_comb begin
      priority if (total > TOTAL_W'(32767)) begin
         sample = 16'sh7fff;
      end else if (total < -TOTAL_W'(32768)) begin
         sample = -16'sh8000;
      end else begin
         sample = SAMPLE_W'(total);
      end
   end

   always_comb begin
      hi_nib_in = hi_nib_ff;
      cmd_pop   = 1'b0;
      rsp_push  = fire;
      if (fire) begin
         if (is_decode) begin
            hi_nib_in = !hi_nib_ff;
            cmd_pop   = hi_nib_ff;
         end else begin
            cmd_pop   = 1'b1;
         end
      end
      rsp_item.sample  = is_decode ? sample : '0;
      rsp_item.channel = cmd_op.channel;
      rsp_item.last    = is_decode && cmd_op.last && hi_nib_ff;
      rsp_item.bad     = !is_decode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_nib_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            h1_ff[i] <= '0;
            h2_ff[i] <= '0;
         end
      end else begin
         hi_nib_ff <= hi_nib_in;
         if (fire && is_decode) begin
            h2_ff[ch_idx] <= h1;
            h1_ff[ch_idx] <= sample;
         end
      end
   end

endmodule

`default_nettype wire

@@ sv/vag_adpcm_block_decoder.sv @@
// Top level of the VAG ADPCM block decoder: front parser, op queue, predictor, result queue.
//
//   channel  direction  handshake          payload
//   req      in         push / full        req_data_byte, req_block_start, req_channel
//   rsp      out        empty / pop        rsp_sample, rsp_sample_channel,
//                                          rsp_last_of_block, rsp_bad_header
//
// A byte transaction is taken every cycle while the op queue has room; the predictor
// turns a data byte into two samples, low nibble first (the second sample depends on the
// first through the channel history), and takes no new op until both are out.
// Header and flags bytes never reach the back end; a bad header queues one error op.
// The first result reaches the rsp ports through the op queue and the result queue.
// Synchronous reset clears block state, channel history and both queues.
// A full result queue stalls only the predictor; the front keeps taking bytes
// until the op queue fills.
`default_nettype none

module vag_adpcm_block_decoder
   import vag_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 2,
   parameter int unsigned CMD_DEPTH    = 4,
   parameter int unsigned RSP_DEPTH    = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // byte transactions
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [BYTE_W-1:0]    req_data_byte,
   input  wire logic                 req_block_start,
   input  wire logic                 req_channel,
   // result transactions
   output logic                      empty,
   input  wire logic                 pop,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                      rsp_sample_channel,
   output logic                      rsp_last_of_block,
   output logic                      rsp_bad_header
);

   localparam int unsigned OP_W  = $bits(op_type);
   localparam int unsigned RSP_W = $bits(rsp_type);

   // front -> op queue
   logic    cmd_push;
   op_type  cmd_wr_op;
   logic    cmd_full;
   // op queue -> back
   logic    cmd_empty;
   logic    cmd_pop;
   op_type  cmd_rd_op;
   // back -> result queue
   logic    rsp_push;
   rsp_type rsp_wr_item;
   logic    rsp_full;
   rsp_type rsp_rd_item;

   vag_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .data_byte   (req_data_byte),
      .block_start (req_block_start),
      .channel     (req_channel),
      .full        (full),
      .cmd_full    (cmd_full),
      .cmd_push    (cmd_push),
      .cmd_op      (cmd_wr_op)
   );

   // decouples header parsing from the serial predictor
   vag_fifo #(
      .WIDTH (OP_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr_op),
      .full    (cmd_full),
      .rd_en   (cmd_pop),
      .rd_data (cmd_rd_op),
      .empty   (cmd_empty)
   );

   vag_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_op    (cmd_rd_op),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_wr_item)
   );

   // registered result queue; the head entry drives the rsp ports
   vag_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_wr_item),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_rd_item),
      .empty   (empty)
   );

   assign rsp_sample         = rsp_rd_item.sample;
   assign rsp_sample_channel = rsp_rd_item.channel;
   assign rsp_last_of_block  = rsp_rd_item.last;
   assign rsp_bad_header     = rsp_rd_item.bad;

endmodule

`default_nettype wire

@@ sv/vag_port_checker.sv @@
// Port-level checker for the VAG ADPCM block decoder, bound to the top level.
`default_nettype none

module vag_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        push,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [15:0] rsp_sample,
   input wire logic        rsp_sample_channel,
   input wire logic        rsp_last_of_block,
   input wire logic        rsp_bad_header
);

   // both queues come out of reset empty
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

   // an error result carries no sample and never closes a block
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_bad_header) |-> (rsp_sample == 16'd0 && !rsp_last_of_block))
      else $error("error result with sample or last flag set");

   // the op queue only fills on an accepted byte transaction
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!full && !push) |=> !full)
      else $error("full rose without a byte transaction");

   // a waiting result holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_sample)
                            && $stable(rsp_sample_channel)
                            && $stable(rsp_last_of_block)
                            && $stable(rsp_bad_header)))
      else $error("stalled result changed");

endmodule

bind vag_adpcm_block_decoder vag_port_checker u_port_checker (
   .clock              (clock),
   .reset              (reset),
   .push               (push),
   .full               (full),
   .empty              (empty),
   .pop                (pop),
   .rsp_sample         (rsp_sample),
   .rsp_sample_channel (rsp_sample_channel),
   .rsp_last_of_block  (rsp_last_of_block),
   .rsp_bad_header     (rsp_bad_header)
);

`default_nettype wire

@@ bench/vag_adpcm_block_decoder_test.sv @@
// Self-checking bench for the VAG ADPCM block decoder: directed rows, then random blocks.
`timescale 1ns / 1ps

module vag_adpcm_block_decoder_test;
   import vag_pkg::*;

   // ------------------------------------------------------------------
   // Run shape
   // ------------------------------------------------------------------
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1150;   // header + block bytes, noise bytes excluded
   localparam int PACE_SPAN    = 64;     // transactions per pacing mode
   localparam int HOLD_AFTER   = 150;    // results before the long receiver hold-off
   localparam int HOLD_CYCLES  = 400;
   // A result passes through the op queue and the result queue, and a data byte gives
   // two samples in turn; with both queues at depth 4 all has drained well within this.
   localparam int DRAIN_CYCLES = 40;

   // How a directed row is checked. ROW_PREDICT rows go through the predictor only;
   // the others carry a typed-in expectation that replaces the predictor's output.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NONE,      // no result at all
      ROW_PAIR,      // two samples, not the last of the block
      ROW_ERROR      // one bad header result
   } row_kind_type;

   typedef enum logic [1:0] {
      PACE_RANDOM,   // random idle gap before each transaction
      PACE_FLAT,     // back to back
      PACE_SPARSE    // mostly back to back, an occasional gap
   } pace_type;

   typedef struct packed {
      logic [BYTE_W-1:0]          data;
      logic                       start;
      logic                       chan;
      row_kind_type               kind;
      logic signed [SAMPLE_W-1:0] s_low;
      logic signed [SAMPLE_W-1:0] s_high;
   } byte_txn_type;

   // ------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       push;
   logic                       full;
   logic [BYTE_W-1:0]          req_data_byte;
   logic                       req_block_start;
   logic                       req_channel;
   logic                       empty;
   logic                       pop;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_sample_channel;
   logic                       rsp_last_of_block;
   logic                       rsp_bad_header;

   vag_adpcm_block_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_data_byte      (req_data_byte),
      .req_block_start    (req_block_start),
      .req_channel        (req_channel),
      .empty              (empty),
      .pop                (pop),
      .rsp_sample         (rsp_sample),
      .rsp_sample_channel (rsp_sample_channel),
      .rsp_last_of_block  (rsp_last_of_block),
      .rsp_bad_header     (rsp_bad_header)
   );

   // ------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------
   byte_txn_type byte_plan[$];        // every byte transaction, in send order
   rsp_type      pending_samples[$];  // expected results, oldest first

   // decoder shadow: per-channel history plus the open block's header
   logic signed [SAMPLE_W-1:0] chan_h1 [0:1];
   logic signed [SAMPLE_W-1:0] chan_h2 [0:1];
   logic [POS_W-1:0]           blk_pos;      // next byte position, 0 = no block open
   logic [FILTER_W-1:0]        blk_filter;
   logic [SHIFT_W-1:0]         blk_shift;
   logic                       blk_chan;
   logic                       blk_dropped;

   bit plan_sent;
   int mismatches;
   int results_seen;
   int header_errors;
   int blocks_closed;
   int saturated;
   int stall_cycles;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic int tap_h1(input logic [FILTER_W-1:0] f);
      case (f)
         3'd1:    return 60;
         3'd2:    return 115;
         3'd3:    return 98;
         3'd4:    return 122;
         default: return 0;
      endcase
   endfunction

   function automatic int tap_h2(input logic [FILTER_W-1:0] f);
      case (f)
         3'd2:    return -52;
         3'd3:    return -55;
         3'd4:    return -60;
         default: return 0;
      endcase
   endfunction

   // One nibble through the open block's filter; shifts the channel history.
   function automatic logic signed [SAMPLE_W-1:0] expand_nibble(input logic [3:0] nib);
      int n, residual, pred, total;
      logic signed [SAMPLE_W-1:0] pcm;
      n = {{28{nib[3]}}, nib};
      residual = (n <<< 12) >>> blk_shift;
      // both arithmetic shifts floor toward minus infinity
      pred = (int'(chan_h1[blk_chan]) * tap_h1(blk_filter)
            + int'(chan_h2[blk_chan]) * tap_h2(blk_filter) + 32) >>> 6;
      total = residual + pred;
      if (total > 32767)
         total = 32767;
      else if (total < -32768)
         total = -32768;
      pcm = total[SAMPLE_W-1:0];
      // two channels and a 1-bit channel field, so the index needs no modulo
      chan_h2[blk_chan] = chan_h1[blk_chan];
      chan_h1[blk_chan] = pcm;
      return pcm;
   endfunction

   // Advances the shadow by one accepted byte; returns how many results it causes.
   function automatic int predict_byte(input logic [BYTE_W-1:0] d, input logic st,
                                       input logic ch, output rsp_type r0,
                                       output rsp_type r1);
      logic [POS_W-1:0] pos;
      r0 = '0;
      r1 = '0;
      if (st) begin
         // header: also abandons an open block, history it already changed stays
         blk_chan   = ch;
         blk_pos    = POS_FLAGS;
         blk_filter = d[6:4];
         blk_shift  = d[3:0];
         blk_dropped = (d[7:4] > MAX_FILTER) || (d[3:0] > MAX_SHIFT);
         if (blk_dropped) begin
            r0.channel = ch;
            r0.bad     = 1'b1;
            return 1;
         end
         return 0;
      end
      if (blk_pos == POS_IDLE)
         return 0;                        // stray byte, nothing open
      pos = blk_pos;
      blk_pos = blk_pos + 4'd1;           // wraps to idle after the 16th byte
      if (pos == POS_FLAGS || blk_dropped)
         return 0;
      r0.sample  = expand_nibble(d[3:0]); // low nibble first
      r0.channel = blk_chan;
      r1.sample  = expand_nibble(d[7:4]);
      r1.channel = blk_chan;
      r1.last    = (pos == POS_LAST);
      return 2;
   endfunction

   // ------------------------------------------------------------------
   // Helpers
   // ------------------------------------------------------------------
   task automatic plan_byte(input logic [BYTE_W-1:0] d, input logic st, input logic ch,
                            input row_kind_type k, input logic signed [SAMPLE_W-1:0] lo,
                            input logic signed [SAMPLE_W-1:0] hi);
      byte_txn_type t;
      t.data   = d;
      t.start  = st;
      t.chan   = ch;
      t.kind   = k;
      t.s_low  = lo;
      t.s_high = hi;
      byte_plan.push_back(t);
   endtask

   function automatic pace_type pick_pace();
      case ($urandom_range(0, 2))
         0:       return PACE_RANDOM;
         1:       return PACE_FLAT;
         default: return PACE_SPARSE;
      endcase
   endfunction

   function automatic int pick_gap(input pace_type p);
      case (p)
         PACE_RANDOM: return $urandom_range(0, 14);
         PACE_FLAT:   return 0;
         default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      endcase
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_samples.size() == 0) begin
         $error("result transaction with nothing expected: sample %0d channel %0d",
                got.sample, got.channel);
         mismatches++;
      end else begin
         want = pending_samples.pop_front();
         check_field("sample", int'(want.sample), int'(got.sample));
         check_field("sample_channel", int'(want.channel), int'(got.channel));
         check_field("last_of_block", int'(want.last), int'(got.last));
         check_field("bad_header", int'(want.bad), int'(got.bad));
      end
      results_seen++;
      if (got.bad)
         header_errors++;
      if (got.last)
         blocks_closed++;
      if (got.sample == 16'sh7fff || got.sample == 16'sh8000)
         saturated++;
   endtask

   // ------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Main: build the plan, reset once, wait for the drain, report
   // ------------------------------------------------------------------
   initial begin : main
      int planned, pick, body, k;
      logic [3:0] hf, hs;
      logic [BYTE_W-1:0] dbyte;

      reset <= 1'b1;
      for (k = 0; k < 2; k++) begin
         chan_h1[k] = '0;
         chan_h2[k] = '0;
      end
      blk_pos = POS_IDLE;
      blk_filter = '0;
      blk_shift = '0;
      blk_chan = 1'b0;
      blk_dropped = 1'b0;

      // Directed rows. Typed expectations only where they are obvious: filter 0
      // with zero history leaves the residual alone, and error results are fixed.
      //        data   start ch    check        low             high
      plan_byte(8'h23, 1'b0, 1'b0, ROW_NONE,    '0,             '0);        // idle byte
      plan_byte(8'h00, 1'b1, 1'b0, ROW_NONE,    '0,             '0);        // f0 s0
      plan_byte(8'hff, 1'b0, 1'b0, ROW_NONE,    '0,             '0);        // flags
      plan_byte(8'h87, 1'b0, 1'b0, ROW_PAIR,    16'sd28672,     16'sh8000); // +7, -8
      plan_byte(8'h00, 1'b0, 1'b0, ROW_PAIR,    '0,             '0);
      plan_byte(8'h0c, 1'b1, 1'b1, ROW_NONE,    '0,             '0);        // f0 s12
      plan_byte(8'h00, 1'b0, 1'b1, ROW_NONE,    '0,             '0);
      plan_byte(8'h87, 1'b0, 1'b1, ROW_PAIR,    16'sd7,         -16'sd8);
      plan_byte(8'h7f, 1'b0, 1'b1, ROW_PAIR,    -16'sd1,        16'sd7);
      plan_byte(8'h50, 1'b1, 1'b1, ROW_ERROR,   '0,             '0);        // filter 5
      plan_byte(8'h12, 1'b0, 1'b1, ROW_NONE,    '0,             '0);        // dropped
      plan_byte(8'h0d, 1'b1, 1'b0, ROW_ERROR,   '0,             '0);        // shift 13
      plan_byte(8'hff, 1'b1, 1'b1, ROW_ERROR,   '0,             '0);        // both bad
      plan_byte(8'h40, 1'b1, 1'b0, ROW_PREDICT, '0,             '0);        // f4 s0
      plan_byte(8'ha5, 1'b0, 1'b0, ROW_PREDICT, '0,             '0);
      plan_byte(8'h77, 1'b0, 1'b0, ROW_PREDICT, '0,             '0);        // clips high
      plan_byte(8'h88, 1'b0, 1'b0, ROW_PREDICT, '0,             '0);        // clips low
      plan_byte(8'h31, 1'b1, 1'b1, ROW_PREDICT, '0,             '0);
      plan_byte(8'h5a, 1'b0, 1'b1, ROW_PREDICT, '0,             '0);
      plan_byte(8'h5a, 1'b0, 1'b0, ROW_PREDICT, '0,             '0);        // ch ignored
      plan_byte(8'h24, 1'b1, 1'b0, ROW_PREDICT, '0,             '0);        // early start
      plan_byte(8'h00, 1'b0, 1'b0, ROW_PREDICT, '0,             '0);
      plan_byte(8'hc3, 1'b0, 1'b0, ROW_PREDICT, '0,             '0);
      plan_byte(8'h4c, 1'b1, 1'b1, ROW_PREDICT, '0,             '0);        // f4 s12
      plan_byte(8'hf0, 1'b0, 1'b1, ROW_PREDICT, '0,             '0);
      plan_byte(8'he1, 1'b0, 1'b1, ROW_PREDICT, '0,             '0);

      // Random part: mostly whole blocks, some cut short by an early start,
      // some with bad headers, and a little noise between blocks.
      planned = 0;
      while (planned < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick >= 90) begin
            repeat ($urandom_range(1, 3))
               plan_byte(8'($urandom), 1'b0, 1'($urandom), ROW_PREDICT, '0, '0);
         end else begin
            if (pick >= 80) begin
               if ($urandom_range(0, 1) == 1) begin
                  hf = 4'($urandom_range(5, 15));
                  hs = 4'($urandom_range(0, 15));
               end else begin
                  hf = 4'($urandom_range(0, 15));
                  hs = 4'($urandom_range(13, 15));
               end
               body = 15;
            end else begin
               hf = 4'($urandom_range(0, 4));
               case ($urandom_range(0, 3))
                  0:       hs = 4'd0;
                  1:       hs = MAX_SHIFT;
                  default: hs = 4'($urandom_range(0, 12));
               endcase
               body = (pick >= 70) ? $urandom_range(0, 13) : 15;
            end
            plan_byte({hf, hs}, 1'b1, 1'($urandom), ROW_PREDICT, '0, '0);
            for (k = 0; k < body; k++) begin
               dbyte = 8'($urandom);
               // full-scale nibbles now and then to push the sum into the clamp
               if ($urandom_range(0, 7) == 0) begin
                  case ($urandom_range(0, 3))
                     0:       dbyte = 8'h77;
                     1:       dbyte = 8'h88;
                     2:       dbyte = 8'h00;
                     default: dbyte = 8'hff;
                  endcase
               end
               plan_byte(dbyte, 1'b0, 1'($urandom), ROW_PREDICT, '0, '0);
            end
            planned += body + 1;
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      wait (plan_sent);
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d byte transactions sent, %0d results checked, input held off %0d cycles",
               byte_plan.size(), results_seen, stall_cycles);
      $display("%0d blocks closed, %0d header errors, %0d clipped samples",
               blocks_closed, header_errors, saturated);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Sender: walks the plan, predicts each byte at the edge it is taken
   // ------------------------------------------------------------------
   initial begin : byte_sender
      int idx, gap, n_out;
      pace_type pace;
      byte_txn_type txn;
      rsp_type r0, r1;

      push <= 1'b0;
      req_data_byte <= '0;
      req_block_start <= 1'b0;
      req_channel <= 1'b0;
      plan_sent = 1'b0;
      pace = PACE_RANDOM;
      do @(posedge clock); while (reset);

      for (idx = 0; idx < byte_plan.size(); idx++) begin
         if (idx % PACE_SPAN == 0)
            pace = pick_pace();
         gap = pick_gap(pace);
         // push only drops when there is a real gap, never low-then-high in one step
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         txn = byte_plan[idx];
         push <= 1'b1;
         req_data_byte <= txn.data;
         req_block_start <= txn.start;
         req_channel <= txn.chan;
         @(posedge clock);
         while (full) begin
            stall_cycles++;
            @(posedge clock);
         end
         // transaction taken at this edge
         n_out = predict_byte(txn.data, txn.start, txn.chan, r0, r1);
         case (txn.kind)
            ROW_NONE:  n_out = 0;
            ROW_PAIR: begin
               n_out = 2;
               r0 = {txn.s_low, txn.chan, 1'b0, 1'b0};
               r1 = {txn.s_high, txn.chan, 1'b0, 1'b0};
            end
            ROW_ERROR: begin
               n_out = 1;
               r0 = {16'sd0, txn.chan, 1'b0, 1'b1};
            end
            default: ;
         endcase
         if (n_out > 0)
            pending_samples.push_back(r0);
         if (n_out > 1)
            pending_samples.push_back(r1);
      end
      push <= 1'b0;
      plan_sent = 1'b1;
   end

   // ------------------------------------------------------------------
   // Receiver: pops with random pacing, one long hold-off to back the block up
   // ------------------------------------------------------------------
   initial begin : result_drain
      int gap;
      pace_type pace;
      bit held_off;

      pop <= 1'b0;
      held_off = 1'b0;
      pace = PACE_RANDOM;
      do @(posedge clock); while (reset);

      forever begin
         if (results_seen % PACE_SPAN == 0)
            pace = pick_pace();
         if (!held_off && results_seen >= HOLD_AFTER) begin
            // result queue fills, then the op queue, then full stalls the sender
            held_off = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = pick_gap(pace);
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         // transaction taken at this edge; ports still show the popped entry
         check_result({rsp_sample, rsp_sample_channel, rsp_last_of_block, rsp_bad_header});
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: fails the run if it goes on far beyond the slowest legal run (every gap
   // at its largest, two results per byte, plus the hold-off).
   // ------------------------------------------------------------------
   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
sv/vag_pkg.sv
sv/vag_fifo.sv
sv/vag_front.sv
sv/vag_back.sv
sv/vag_adpcm_block_decoder.sv
sv/vag_port_checker.sv
bench/vag_adpcm_block_decoder_test.sv
